>>> rtl/sld_pkg.sv
// shared types and constants for the sync/length packet deframer
// no dependencies; imported by the top level, sld_rx and sld_rd (not by sld_ram)
`default_nettype none

package sld_pkg;

  localparam int unsigned BufferDepth = 64;
  localparam int unsigned AddrW       = $clog2(BufferDepth);
  localparam int unsigned CntW        = $clog2(BufferDepth + 1);

  localparam logic [7:0]      SyncByte      = 8'hFF;
  localparam logic [CntW-1:0] LimitReset    = CntW'(BufferDepth);
  localparam logic [0:0]      RegBufferLimit = 1'b0;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_LEN_CPY = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } sld_phase_e;

  typedef enum logic [1:0] {
    RD_IDLE   = 2'd0,
    RD_STREAM = 2'd1,
    RD_SINGLE = 2'd2
  } sld_rd_state_e;

  // end of frame notice from the receive side to the readout side
  typedef struct packed {
    logic            valid;
    logic            ok;
    logic [CntW-1:0] len;
  } sld_frame_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } sld_wr_t;

endpackage

`default_nettype wire

>>> rtl/sync_length_packet_deframer.sv
// output: the single word of a failed or empty packet is valid the cycle after the last
// check byte is accepted, the first word of a payload run once the ram read is registered
// throughput: one received byte per cycle; the run then drains at one word per cycle
// while the output is ready (payload RAM read port); input is stalled until it is delivered
// reset: rst_ni asynchronously clears control state and sets buffer_limit to 64;
// the payload RAM is not cleared, entries are only read after a frame writes them
`default_nettype none

module sync_length_packet_deframer
  import sld_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // apb configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // received bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] payload_byte, [13:8] byte_index,
                                           // [20:14] packet_length, [23:21] zero
  output logic [1:0]       m_axis_tuser,   // [0] has_byte, [1] checksum_ok
  output logic             m_axis_tlast    // last_of_run
);

  logic [CntW-1:0] limit_q;
  logic            cfg_wr;
  logic            accept;
  logic            busy;
  sld_wr_t         wr;
  sld_frame_t      frame;
  logic            re;
  logic [AddrW-1:0] raddr;
  logic [7:0]      rdata;
  logic [7:0]      payload_byte;
  logic [AddrW-1:0] byte_index;
  logic            has_byte;
  logic            checksum_ok;
  logic [CntW-1:0] packet_length;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == RegBufferLimit);
  assign prdata = (paddr[2:2] == RegBufferLimit) ? 32'(limit_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_wr) begin
      limit_q <= pwdata[CntW-1:0];
    end
  end

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;

  sld_rx u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (s_axis_tdata),
    .limit_i   (limit_q),
    .wr_o      (wr),
    .frame_o   (frame)
  );

  sld_ram #(
    .Width (8),
    .Depth (BufferDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sld_rd u_rd (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frame_i         (frame),
    .busy_o          (busy),
    .re_o            (re),
    .raddr_o         (raddr),
    .rdata_i         (rdata),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .payload_byte_o  (payload_byte),
    .byte_index_o    (byte_index),
    .has_byte_o      (has_byte),
    .checksum_ok_o   (checksum_ok),
    .packet_length_o (packet_length),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, packet_length, byte_index, payload_byte};
  assign m_axis_tuser = {checksum_ok, has_byte};

endmodule

`default_nettype wire

>>> rtl/sld_ram.sv
// generic single-port-write, single-port-read RAM with registered read data
// no dependencies
`default_nettype none

module sld_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/sld_rx.sv
// receive side: frame parser, running sums and payload store write port
// depends on sld_pkg
`default_nettype none

module sld_rx
  import sld_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic [CntW-1:0] limit_i,
  output sld_wr_t              wr_o,
  output sld_frame_t           frame_o
);

  sld_phase_e      phase_q, phase_d;
  logic [7:0]      remaining_q, remaining_d;
  logic [7:0]      sum_lo_q, sum_lo_d;
  logic [7:0]      sum_hi_q, sum_hi_d;
  logic [7:0]      rx_hi_q, rx_hi_d;
  logic            hi_pend_q, hi_pend_d;
  logic [CntW-1:0] wr_idx_q, wr_idx_d;

  logic [CntW-1:0] eff_limit;
  logic [CntW-1:0] wr_idx_inc;
  logic [7:0]      rem_dec;
  logic [7:0]      sum_lo_new;

  always_comb begin
    if (limit_i == '0) begin
      eff_limit = CntW'(1);
    end else if (limit_i > CntW'(BufferDepth)) begin
      eff_limit = CntW'(BufferDepth);
    end else begin
      eff_limit = limit_i;
    end
  end

  assign wr_idx_inc = wr_idx_q + CntW'(1);
  assign rem_dec    = remaining_q - 8'd1;
  assign sum_lo_new = sum_lo_q + rx_byte_i;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == SyncByte) phase_d = PH_LEN;
        end
        PH_LEN: phase_d = PH_LEN_CPY;
        PH_LEN_CPY: begin
          if (rx_byte_i != remaining_q) begin
            phase_d = PH_HUNT;
          end else if (remaining_q == 8'd0) begin
            phase_d = PH_CHECK;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (rem_dec == 8'd0) begin
            phase_d = PH_CHECK;
          end else if (wr_idx_inc >= eff_limit) begin
            phase_d = PH_HUNT;
          end
        end
        PH_CHECK: begin
          if (!hi_pend_q) phase_d = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  // datapath and outputs
  always_comb begin
    remaining_d   = remaining_q;
    sum_lo_d      = sum_lo_q;
    sum_hi_d      = sum_hi_q;
    rx_hi_d       = rx_hi_q;
    hi_pend_d     = hi_pend_q;
    wr_idx_d      = wr_idx_q;
    wr_o.we       = 1'b0;
    wr_o.addr     = wr_idx_q[AddrW-1:0];
    wr_o.data     = rx_byte_i;
    frame_o.valid = 1'b0;
    frame_o.ok    = (rx_hi_q == sum_hi_q) && (rx_byte_i == sum_lo_q);
    frame_o.len   = wr_idx_q;
    if (accept_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == SyncByte) begin
            remaining_d = 8'd0;
            sum_lo_d    = 8'd0;
            sum_hi_d    = 8'd0;
            rx_hi_d     = 8'd0;
            hi_pend_d   = 1'b0;
            wr_idx_d    = '0;
          end
        end
        PH_LEN: remaining_d = rx_byte_i;
        PH_LEN_CPY: begin
          if (rx_byte_i == remaining_q && remaining_q == 8'd0) hi_pend_d = 1'b1;
        end
        PH_PAYLOAD: begin
          // write index never passes the depth: the frame ends or drops first
          wr_o.we     = 1'b1;
          wr_idx_d    = wr_idx_inc;
          sum_lo_d    = sum_lo_new;
          sum_hi_d    = sum_hi_q + sum_lo_new;
          remaining_d = rem_dec;
          if (rem_dec == 8'd0) hi_pend_d = 1'b1;
        end
        PH_CHECK: begin
          if (hi_pend_q) begin
            rx_hi_d   = rx_byte_i;
            hi_pend_d = 1'b0;
          end else begin
            frame_o.valid = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      remaining_q <= 8'd0;
      sum_lo_q    <= 8'd0;
      sum_hi_q    <= 8'd0;
      rx_hi_q     <= 8'd0;
      hi_pend_q   <= 1'b0;
      wr_idx_q    <= '0;
    end else begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      sum_lo_q    <= sum_lo_d;
      sum_hi_q    <= sum_hi_d;
      rx_hi_q     <= rx_hi_d;
      hi_pend_q   <= hi_pend_d;
      wr_idx_q    <= wr_idx_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sld_rd.sv
// readout sequencer: reads the payload store back one word per cycle while the output is ready
// depends on sld_pkg; drives the read port of the payload RAM
`default_nettype none

module sld_rd
  import sld_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sld_frame_t       frame_i,
  output logic                  busy_o,
  output logic                  re_o,
  output logic [AddrW-1:0]      raddr_o,
  input  wire logic [7:0]       rdata_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            payload_byte_o,
  output logic [AddrW-1:0]      byte_index_o,
  output logic                  has_byte_o,
  output logic                  checksum_ok_o,
  output logic [CntW-1:0]       packet_length_o,
  output logic                  last_o
);

  sld_rd_state_e   state_q, state_d;
  logic [CntW-1:0] addr_q, addr_d;
  logic [CntW-1:0] len_q, len_d;
  logic            ok_q, ok_d;
  logic            has_q, has_d;
  logic            valid_q, valid_d;
  logic            last_q, last_d;
  logic [AddrW-1:0] idx_q, idx_d;

  logic out_free;
  logic more;
  logic fire;

  assign out_free = !valid_q || out_ready_i;
  assign more     = (addr_q != len_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      RD_IDLE: begin
        if (frame_i.valid) begin
          state_d = (frame_i.ok && frame_i.len != '0) ? RD_STREAM : RD_SINGLE;
        end
      end
      RD_STREAM: begin
        if (!more && out_free) state_d = RD_IDLE;
      end
      RD_SINGLE: begin
        if (out_ready_i) state_d = RD_IDLE;
      end
      default: state_d = RD_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    fire    = 1'b0;
    addr_d  = addr_q;
    len_d   = len_q;
    ok_d    = ok_q;
    has_d   = has_q;
    valid_d = valid_q;
    last_d  = last_q;
    idx_d   = idx_q;
    case (state_q)
      RD_IDLE: begin
        if (frame_i.valid) begin
          addr_d = '0;
          len_d  = frame_i.len;
          ok_d   = frame_i.ok;
          idx_d  = '0;
          if (frame_i.ok && frame_i.len != '0) begin
            has_d   = 1'b1;
            valid_d = 1'b0;
          end else begin
            // failure or empty packet: one word, no payload
            has_d   = 1'b0;
            valid_d = 1'b1;
            last_d  = 1'b1;
          end
        end
      end
      RD_STREAM: begin
        if (more && out_free) begin
          fire    = 1'b1;
          addr_d  = addr_q + CntW'(1);
          idx_d   = addr_q[AddrW-1:0];
          last_d  = (addr_q + CntW'(1)) == len_q;
          valid_d = 1'b1;
        end else if (out_ready_i) begin
          valid_d = 1'b0;
        end
      end
      RD_SINGLE: begin
        if (out_ready_i) valid_d = 1'b0;
      end
      default: valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RD_IDLE;
      valid_q <= 1'b0;
      addr_q  <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      addr_q  <= addr_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q   <= ok_d;
    has_q  <= has_d;
    last_q <= last_d;
    idx_q  <= idx_d;
  end

  assign busy_o          = (state_q != RD_IDLE);
  assign re_o            = fire;
  assign raddr_o         = addr_q[AddrW-1:0];
  assign out_valid_o     = valid_q;
  // ram read data holds between fires, so it can feed the output directly
  assign payload_byte_o  = has_q ? rdata_i : 8'd0;
  assign byte_index_o    = idx_q;
  assign has_byte_o      = has_q;
  assign checksum_ok_o   = ok_q;
  assign packet_length_o = len_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire
